// ===== src/sfd_pkg.sv =====
package sfd_pkg;

   localparam logic [7:0] START_BYTE = 8'h02;
   localparam logic [7:0] STOP_BYTE  = 8'h03;
   localparam logic [7:0] LEN_MASK   = 8'h7f;

   // one result of the deframer, valid marks that the byte produced one
   typedef struct packed {
      logic       valid;
      logic [7:0] field_byte;
      logic [6:0] field_index;
      logic       frame_done;
   } result_type;

endpackage

// ===== src/sfd_if.sv =====
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] field_byte;
   logic [6:0] field_index;
   logic       frame_done;

   modport source (output valid, output field_byte, output field_index,
                   output frame_done, input ready);
   modport sink   (input valid, input field_byte, input field_index,
                   input frame_done, output ready);
endinterface

// ===== src/sfd_core.sv =====
module sfd_core
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] rx_byte,
   output result_type result
);

   typedef enum logic [1:0] {
      PHASE_HUNT = 2'd0,
      PHASE_LEN  = 2'd1,
      PHASE_BODY = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [6:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [6:0] position_ff, position_in;
   logic       escape_ff, escape_in;

   logic [7:0] count_inc;
   logic [7:0] limit;
   logic       special;

   assign count_inc = count_ff + 8'd1;
   assign limit     = {1'b0, length_ff} + 8'd1;
   assign special   = (rx_byte == START_BYTE) || (rx_byte == STOP_BYTE);

   always_comb begin
      phase_in    = phase_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      position_in = position_ff;
      escape_in   = escape_ff;
      result      = '0;
      case (phase_ff)
         PHASE_HUNT: begin
            if (rx_byte == START_BYTE) begin
               phase_in = PHASE_LEN;
               count_in = '0;
            end
         end
         PHASE_LEN: begin
            length_in   = 7'(rx_byte & LEN_MASK);
            count_in    = '0;
            position_in = '0;
            escape_in   = 1'b0;
            phase_in    = PHASE_BODY;
         end
         PHASE_BODY: begin
            count_in = count_inc;
            if (count_inc > limit) begin
               // overrun past the closing count, drop frame
               phase_in  = PHASE_HUNT;
               escape_in = 1'b0;
            end else if (rx_byte == STOP_BYTE && count_inc == limit) begin
               phase_in          = PHASE_HUNT;
               escape_in         = 1'b0;
               result.valid      = 1'b1;
               result.frame_done = 1'b1;
            end else if (special && !escape_ff) begin
               // first copy of a doubled byte is dropped
               escape_in = 1'b1;
            end else begin
               escape_in          = 1'b0;
               result.valid       = 1'b1;
               result.field_byte  = rx_byte;
               result.field_index = position_ff;
               position_in        = position_ff + 7'd1;
            end
         end
         default: begin
            phase_in = PHASE_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_HUNT;
         length_ff   <= '0;
         count_ff    <= '0;
         position_ff <= '0;
         escape_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         position_ff <= position_in;
         escape_ff   <= escape_in;
      end
   end

endmodule

// ===== src/stuffed_frame_deframer_top.sv =====
// channel  direction  payload
// req      in         rx_byte[7:0]
// rsp      out        field_byte[7:0], field_index[6:0], frame_done
//
// one byte per cycle sustained while rsp is ready; a byte goes input register
// -> state update -> result register, which presents its result on rsp.
// synchronous reset returns the deframer to hunting for a start byte.
// a held byte waits in the input register while an untaken result sits in the
// result register, whether or not the byte gives a result itself.
// with rsp stalled the input register still takes one more byte.
module stuffed_frame_deframer_top
   import sfd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sfd_req_if.sink   req_chan,
   sfd_rsp_if.source rsp_chan
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic [6:0] out_index_ff;
   logic       out_done_ff;

   logic       advance;
   result_type result;

   // held byte moves on when the result register is free or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   sfd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_chan.rx_byte;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= result.valid;
            if (result.valid) begin
               out_byte_ff  <= result.field_byte;
               out_index_ff <= result.field_index;
               out_done_ff  <= result.frame_done;
            end
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.field_byte  = out_byte_ff;
   assign rsp_chan.field_index = out_index_ff;
   assign rsp_chan.frame_done  = out_done_ff;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import sfd_pkg::*;

   localparam int N_DIRECTED  = 24;
   localparam int N_RANDOM    = 900;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 8;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } frame_phase_type;

   // a directed row; when typed is set the result is given here directly
   typedef struct packed {
      logic [7:0] rx;
      logic       typed;
      result_type want;
   } stim_row_type;

   localparam result_type NO_RESULT = '0;

   const stim_row_type DIRECTED [N_DIRECTED] = '{
      '{8'h55, 1'b1, NO_RESULT},                         // noise while hunting
      '{START_BYTE, 1'b0, NO_RESULT},
      '{8'h85, 1'b0, NO_RESULT},                         // length 5, top bit masked
      '{8'h00, 1'b1, '{1'b1, 8'h00, 7'd0, 1'b0}},
      '{8'hff, 1'b1, '{1'b1, 8'hff, 7'd1, 1'b0}},
      '{START_BYTE, 1'b0, NO_RESULT},
      '{START_BYTE, 1'b0, NO_RESULT},                    // doubled start kept
      '{STOP_BYTE, 1'b0, NO_RESULT},                     // escape left pending
      '{STOP_BYTE, 1'b1, '{1'b1, 8'h00, 7'd0, 1'b1}},    // stop wins over escape
      '{START_BYTE, 1'b0, NO_RESULT},
      '{8'h03, 1'b0, NO_RESULT},                         // length 3
      '{STOP_BYTE, 1'b0, NO_RESULT},
      '{START_BYTE, 1'b0, NO_RESULT},                    // escape closed by other special
      '{START_BYTE, 1'b0, NO_RESULT},
      '{8'h41, 1'b0, NO_RESULT},                         // plain byte clears escape
      '{STOP_BYTE, 1'b1, NO_RESULT},                     // count overrun
      '{STOP_BYTE, 1'b0, NO_RESULT},
      '{START_BYTE, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},                         // empty body
      '{STOP_BYTE, 1'b1, '{1'b1, 8'h00, 7'd0, 1'b1}},
      '{START_BYTE, 1'b0, NO_RESULT},
      '{8'h80, 1'b0, NO_RESULT},
      '{START_BYTE, 1'b0, NO_RESULT},
      '{START_BYTE, 1'b0, NO_RESULT}
   };

   logic clock;
   logic reset;

   sfd_req_if req_chan ();
   sfd_rsp_if rsp_chan ();

   stuffed_frame_deframer_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // deframer model state
   frame_phase_type phase_now;
   logic [6:0]      frame_len;
   logic [7:0]      body_cnt;
   logic [6:0]      next_pos;
   logic            esc_pending;

   logic [7:0]  rx_stream [$];
   result_type  deframed_q [$];
   int          next_send;
   int          rx_taken;
   int          idle_stage;
   int          stall_cycles;
   int          mismatch_count;
   result_type  predicted;
   result_type  wanted;

   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type r;
      logic [8:0] last_count;
      r = '0;
      case (phase_now)
         PH_HUNT: begin
            if (b == START_BYTE) begin
               phase_now = PH_LENGTH;
               body_cnt  = '0;
            end
         end
         PH_LENGTH: begin
            frame_len   = 7'(b & LEN_MASK);
            body_cnt    = '0;
            next_pos    = '0;
            esc_pending = 1'b0;
            phase_now   = PH_BODY;
         end
         PH_BODY: begin
            body_cnt   = body_cnt + 8'd1;
            last_count = {2'b00, frame_len} + 9'd1;
            if ({1'b0, body_cnt} > last_count) begin
               phase_now   = PH_HUNT;
               esc_pending = 1'b0;
            end else if (b == STOP_BYTE && {1'b0, body_cnt} == last_count) begin
               phase_now    = PH_HUNT;
               esc_pending  = 1'b0;
               r.valid      = 1'b1;
               r.frame_done = 1'b1;
            end else if ((b == START_BYTE || b == STOP_BYTE) && !esc_pending) begin
               esc_pending = 1'b1;
            end else begin
               esc_pending   = 1'b0;
               r.valid       = 1'b1;
               r.field_byte  = b;
               r.field_index = next_pos;
               next_pos      = next_pos + 7'd1;
            end
         end
         default: phase_now = PH_HUNT;
      endcase
      return r;
   endfunction

   // mostly well-formed stuffed frames, some noise and some broken ones
   task automatic build_random_frames();
      logic [7:0] frame [$];
      logic [7:0] data;
      int len;
      int filled;
      int pos;
      while (rx_stream.size() < N_DIRECTED + N_RANDOM) begin
         frame.delete();
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(4, 1)) frame.push_back(8'($urandom_range(255)));
         end
         len = ($urandom_range(99) < 3) ? $urandom_range(127, 100) : $urandom_range(16);
         frame.push_back(START_BYTE);
         frame.push_back({1'($urandom_range(1)), 7'(len)});
         filled = 0;
         while (filled < len) begin
            if ($urandom_range(4) == 0)
               data = $urandom_range(1) ? START_BYTE : STOP_BYTE;
            else
               data = 8'($urandom_range(255));
            if (data == START_BYTE || data == STOP_BYTE) begin
               if (filled + 2 <= len) begin
                  frame.push_back(data);
                  frame.push_back(data);
                  filled += 2;
               end else begin
                  frame.push_back(8'($urandom_range(255, 4)));
                  filled += 1;
               end
            end else begin
               frame.push_back(data);
               filled += 1;
            end
         end
         frame.push_back(STOP_BYTE);
         if ($urandom_range(99) < 15) begin
            pos = $urandom_range(frame.size() - 1);
            case ($urandom_range(3))
               0: frame[pos] = 8'($urandom_range(255));
               1: void'(frame.pop_back());
               2: frame.insert(frame.size() - 1, 8'($urandom_range(255)));
               default: frame.insert(pos, $urandom_range(1) ? START_BYTE : STOP_BYTE);
            endcase
         end
         foreach (frame[i]) rx_stream.push_back(frame[i]);
      end
   endtask

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // byte source
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (next_send < rx_stream.size() &&
             $urandom_range(99) >= (idle_stage == 0 ? 10 : idle_stage == 1 ? 62 : 0)) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= rx_stream[next_send];
            next_send        <= next_send + 1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <=
            $urandom_range(99) >= (idle_stage == 0 ? 62 : idle_stage == 1 ? 10 : 0);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predicted = deframe_byte(req_chan.rx_byte);
            if (rx_taken < N_DIRECTED && DIRECTED[rx_taken].typed)
               predicted = DIRECTED[rx_taken].want;
            if (predicted.valid)
               deframed_q.push_back(predicted);
            rx_taken   <= rx_taken + 1;
            idle_stage <= (rx_taken + 1) * 3 / rx_stream.size();
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (deframed_q.size() == 0) begin
               $display("%0t: unexpected result byte %h index %0d done %b", $time,
                        rsp_chan.field_byte, rsp_chan.field_index, rsp_chan.frame_done);
               mismatch_count <= mismatch_count + 1;
            end else begin
               wanted = deframed_q.pop_front();
               if (rsp_chan.field_byte !== wanted.field_byte ||
                   rsp_chan.field_index !== wanted.field_index ||
                   rsp_chan.frame_done !== wanted.frame_done) begin
                  $display({"%0t: expected byte %h index %0d done %b, ",
                            "actual byte %h index %0d done %b"},
                           $time, wanted.field_byte, wanted.field_index, wanted.frame_done,
                           rsp_chan.field_byte, rsp_chan.field_index, rsp_chan.frame_done);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      phase_now        = PH_HUNT;
      frame_len        = '0;
      body_cnt         = '0;
      next_pos         = '0;
      esc_pending      = 1'b0;
      next_send        = 0;
      rx_taken         = 0;
      idle_stage       = 0;
      stall_cycles     = 0;
      mismatch_count   = 0;
      foreach (DIRECTED[i]) rx_stream.push_back(DIRECTED[i].rx);
      build_random_frames();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (rx_taken < rx_stream.size()) @(negedge clock);
      while (deframed_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatch_count == 0 && deframed_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
